// File: design/lph_pkg.sv
// Shared constants, codes and controller/datapath types for the hash table.
package lph_pkg;

    localparam int KEY_W           = 64;
    localparam int VALUE_W         = 32;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int COUNT_OUT_W     = 7;
    localparam int TABLE_SLOTS_DEF = 64;
    localparam int VALUE_BITS_DEF  = 32;

    localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISSING  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ZERO_KEY = 2'd3;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_HASH,
        FSM_SCAN,
        FSM_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic clear_run;
        logic accept;
        logic hash_run;
        logic scan_start;
        logic scan_run;
        logic load_out;
    } lph_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic hash_done;
        logic skip;
        logic scan_done;
        logic out_free;
    } lph_stat_t;

endpackage

// File: design/lph_req_if.sv
// Request channel: operation word into the table.
interface lph_req_if;
    import lph_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output mode, output key, output value, input ready);
    modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

// File: design/lph_rsp_if.sv
// Response channel: one result word per request.
interface lph_rsp_if;
    import lph_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [VALUE_W-1:0]     read_value;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, output found, output read_value, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input found, input read_value, input status,
                    input entry_count, output ready);
endinterface

// File: design/lph_ctrl.sv
// Operation sequencer: clear pass, hash, slot scan and result hand-off.
module lph_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  lph_pkg::lph_stat_t stat,
    output lph_pkg::lph_cmd_t  cmd
);
    import lph_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_CLEAR:
            begin
                if (stat.clear_done)
                    state_next = FSM_IDLE;
            end
            FSM_IDLE:
            begin
                if (req_valid)
                    state_next = FSM_HASH;
            end
            FSM_HASH:
            begin
                if (stat.hash_done)
                    state_next = stat.skip ? FSM_FINISH : FSM_SCAN;
            end
            FSM_SCAN:
            begin
                if (stat.scan_done)
                    state_next = FSM_FINISH;
            end
            FSM_FINISH:
            begin
                if (stat.out_free)
                    state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            FSM_CLEAR:
            begin
                cmd.clear_run = 1'b1;
            end
            FSM_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            FSM_HASH:
            begin
                cmd.hash_run   = 1'b1;
                cmd.scan_start = stat.hash_done && !stat.skip;
            end
            FSM_SCAN:
            begin
                cmd.scan_run = 1'b1;
            end
            FSM_FINISH:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: design/lph_dp.sv
// Datapath: slot memories, start-slot hash, probe pipeline and result register.
module lph_dp #(
    parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF,
    parameter int VALUE_BITS  = lph_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lph_pkg::lph_cmd_t                 cmd,
    output lph_pkg::lph_stat_t                stat,
    input  logic [lph_pkg::MODE_W-1:0]        req_mode,
    input  logic [lph_pkg::KEY_W-1:0]         req_key,
    input  logic [lph_pkg::VALUE_W-1:0]       req_value,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic                              rsp_found,
    output logic [lph_pkg::VALUE_W-1:0]       rsp_read_value,
    output logic [lph_pkg::STATUS_W-1:0]      rsp_status,
    output logic [lph_pkg::COUNT_OUT_W-1:0]   rsp_entry_count
);
    import lph_pkg::*;

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int STORE_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(TABLE_SLOTS);

    logic [KEY_W-1:0]   key_mem [TABLE_SLOTS];
    logic [STORE_W-1:0] val_mem [TABLE_SLOTS];

    logic [MODE_W-1:0]   mode_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [STORE_W-1:0]  val_reg;
    logic [SLOT_W-1:0]   idx_reg,   idx_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0]   chk_idx_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                found_reg, found_next;
    logic [STORE_W-1:0]  rd_reg,    rd_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                skip_reg;
    logic [KEY_W-1:0]    rkey_reg;
    logic [STORE_W-1:0]  rval_reg;
    logic                out_valid_reg;

    logic [SLOT_W-1:0]   hash_slot;
    logic                hash_done;
    logic                issue;
    logic                hit;
    logic                mem_we;
    logic                val_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [KEY_W-1:0]    mem_wkey;
    logic                req_key_zero;
    logic                table_full;

    // Start slot = key mod TABLE_SLOTS
    if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0)
    begin : g_hash_mask
        assign hash_slot = key_reg[SLOT_W-1:0];
        assign hash_done = 1'b1;
    end
    else
    begin : g_hash_recip
        // 16-bit key chunks, MSB first, each in turn: quotient estimate by
        // reciprocal (low by at most one), then remainder with one correction
        localparam int CHUNK_W     = 16;
        localparam int CHUNKS      = KEY_W / CHUNK_W;
        localparam int CHUNK_CNT_W = $clog2(CHUNKS + 1);
        localparam int CHUNK_IDX_W = $clog2(CHUNKS);
        localparam int X_W         = SLOT_W + CHUNK_W;
        localparam int RECIP_W     = CHUNK_W + 1;
        localparam int PROD_W      = X_W + RECIP_W;
        localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << X_W) / TABLE_SLOTS);
        localparam logic [X_W-1:0]     MOD_VAL = X_W'(TABLE_SLOTS);

        logic [SLOT_W-1:0]      rem_reg;
        logic [CHUNK_W-1:0]     q_reg;
        logic [CHUNK_CNT_W-1:0] chunk_reg;
        logic                   phase_reg;
        logic [CHUNK_W-1:0]     chunk;
        logic [X_W-1:0]         x_val;
        logic [PROD_W-1:0]      prod;
        logic [X_W-1:0]         qm;
        logic [X_W-1:0]         rem_raw;
        logic [X_W-1:0]         rem_red;

        assign chunk     = key_reg[(CHUNKS - 1 - int'(chunk_reg[CHUNK_IDX_W-1:0])) * CHUNK_W
                                   +: CHUNK_W];
        assign x_val     = {rem_reg, chunk};
        assign prod      = PROD_W'(x_val) * PROD_W'(RECIP);
        assign qm        = X_W'(q_reg) * MOD_VAL;
        assign rem_raw   = x_val - qm;
        assign rem_red   = (rem_raw >= MOD_VAL) ? (rem_raw - MOD_VAL) : rem_raw;
        assign hash_done = (chunk_reg == CHUNK_CNT_W'(CHUNKS));
        assign hash_slot = rem_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                chunk_reg <= '0;
                phase_reg <= 1'b0;
            end
            else if (cmd.accept)
            begin
                chunk_reg <= '0;
                phase_reg <= 1'b0;
            end
            else if (cmd.hash_run && !hash_done)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                    chunk_reg <= chunk_reg + 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.accept)
                rem_reg <= '0;
            else if (cmd.hash_run && !hash_done && phase_reg)
                rem_reg <= rem_red[SLOT_W-1:0];
            if (cmd.hash_run && !hash_done && !phase_reg)
                q_reg <= prod[X_W +: CHUNK_W];
        end
    end

    assign req_key_zero = (req_key == '0);
    assign table_full   = (count_reg >= SLOTS_CNT);

    // Probe pipeline: address goes out in one cycle, key is compared the next.
    assign issue = cmd.scan_run && (issue_reg != SLOTS_CNT);
    assign hit   = cmd.scan_run && chk_vld_reg &&
                   ((mode_reg == MODE_PUT) ? (rkey_reg == '0) : (rkey_reg == key_reg));

    always_comb
    begin
        idx_next     = idx_reg;
        issue_next   = issue_reg;
        chk_vld_next = 1'b0;
        count_next   = count_reg;
        found_next   = found_reg;
        rd_next      = rd_reg;
        status_next  = status_reg;
        mem_we       = 1'b0;
        val_we       = 1'b0;
        mem_waddr    = chk_idx_reg;
        mem_wkey     = '0;

        if (cmd.clear_run)
        begin
            mem_we    = 1'b1;
            mem_waddr = idx_reg;
            idx_next  = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
        end

        if (cmd.accept)
        begin
            found_next = 1'b0;
            rd_next    = '0;
            case (req_mode)
                MODE_PUT:
                begin
                    if (req_key_zero)
                        status_next = STAT_ZERO_KEY;
                    else
                        status_next = STAT_FULL;
                end
                MODE_GET, MODE_REMOVE:
                begin
                    status_next = req_key_zero ? STAT_ZERO_KEY : STAT_MISSING;
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end

        if (cmd.scan_start)
        begin
            idx_next   = hash_slot;
            issue_next = '0;
        end

        if (issue)
        begin
            idx_next     = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
            issue_next   = issue_reg + 1'b1;
            chk_vld_next = 1'b1;
        end

        if (hit)
        begin
            status_next = STAT_OK;
            case (mode_reg)
                MODE_PUT:
                begin
                    mem_we     = 1'b1;
                    val_we     = 1'b1;
                    mem_wkey   = key_reg;
                    count_next = count_reg + 1'b1;
                end
                MODE_GET:
                begin
                    found_next = 1'b1;
                    rd_next    = rval_reg;
                end
                default:
                begin
                    mem_we     = 1'b1;
                    found_next = 1'b1;
                    if (count_reg != '0)
                        count_next = count_reg - 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            issue_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            issue_reg   <= issue_next;
            chk_vld_reg <= chk_vld_next;
            count_reg   <= count_next;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg   <= found_next;
        rd_reg      <= rd_next;
        status_reg  <= status_next;
        chk_idx_reg <= idx_reg;
        if (cmd.accept)
        begin
            mode_reg <= req_mode;
            key_reg  <= req_key;
            val_reg  <= req_value[STORE_W-1:0];
            skip_reg <= req_key_zero ||
                        !(req_mode inside {MODE_PUT, MODE_GET, MODE_REMOVE}) ||
                        (req_mode == MODE_PUT && table_full);
        end
        if (cmd.load_out)
        begin
            rsp_found       <= found_reg;
            rsp_read_value  <= VALUE_W'(rd_reg);
            rsp_status      <= status_reg;
            rsp_entry_count <= COUNT_OUT_W'(count_reg);
        end
    end

    // Slot memories: one write port, one registered read port each.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            key_mem[mem_waddr] <= mem_wkey;
        rkey_reg <= key_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[mem_waddr] <= val_reg;
        rval_reg <= val_mem[idx_reg];
    end

    assign rsp_valid = out_valid_reg;

    assign stat.clear_done = cmd.clear_run && (idx_reg == LAST_SLOT);
    assign stat.hash_done  = hash_done;
    assign stat.skip       = skip_reg;
    assign stat.scan_done  = (hit && mode_reg != MODE_REMOVE) ||
                             (cmd.scan_run && chk_vld_reg && issue_reg == SLOTS_CNT);
    assign stat.out_free   = !out_valid_reg || rsp_ready;

endmodule

// File: design/linear_probe_hash_table_top.sv
// Top level of the linear-probing key/value table.
//
//   channel | dir | fields                                  | accepted when
//   req     | in  | mode, key, value                        | valid && ready
//   rsp     | out | found, read_value, status, entry_count  | valid && ready
//
// After reset a clearing pass zeroes every slot of the key store, with req.ready low.
// One word at a time: the start-slot hash is a bit mask for a power-of-two table, else a
// reduction over 16-bit key chunks. The scan reads one slot per cycle from the key
// store's single read port; put and get stop at the first hit.
// The response register is loaded once it is free; a stalled rsp holds its word and the next
// req word is taken while it waits.
module linear_probe_hash_table_top #(
    parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF,
    parameter int VALUE_BITS  = lph_pkg::VALUE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lph_req_if.sink    req,
    lph_rsp_if.source  rsp
);
    import lph_pkg::*;

    lph_cmd_t  cmd;
    lph_stat_t stat;

    lph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lph_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_mode        (req.mode),
        .req_key         (req.key),
        .req_value       (req.value),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_found       (rsp.found),
        .rsp_read_value  (rsp.read_value),
        .rsp_status      (rsp.status),
        .rsp_entry_count (rsp.entry_count)
    );

`ifndef SYNTHESIS
    // a match always reports ok
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.found |-> rsp.status == STAT_OK)
        else $error("found word with non-ok status");

    // a returned value only comes with a match
    a_value_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.read_value != '0 |-> rsp.found)
        else $error("read_value without match");

    // no request is taken while the clear, hash or scan is running
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_run || cmd.hash_run || cmd.clear_run |-> !req.ready)
        else $error("request accepted while busy");

    // the response register is loaded only when it is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !rsp.valid || rsp.ready)
        else $error("response overwritten");
`endif

endmodule
